@@ design/tbac_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tbac_pkg
// Shared widths, register indexes and the calibration settings type of the
// trimmed block average calibration core.
// ----------------------------------------------------------------------------
package tbac_pkg;

	localparam int SAMPLE_W  = 12;
	localparam int SUM_W     = 16;
	localparam int VOLT_W    = 16;
	localparam int GAIN_W    = 16;
	localparam int CFG_W     = 16;
	localparam int CFG_IDX_W = 1;

	localparam logic [GAIN_W-1:0] GAIN_RST   = 16'd10000;
	localparam logic [CFG_W-1:0]  OFFSET_RST = 16'd0;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_GAIN   = 1'b0,
		CFG_OFFSET = 1'b1
	} cfg_idx_t;

	typedef struct packed {
		logic        [GAIN_W-1:0] gain;
		logic signed [CFG_W-1:0]  offset;
	} cfg_t;

endpackage

@@ design/trimmed_block_average_calibrate_core.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// trimmed_block_average_calibrate_core
// One voltage channel: trimmed mean over blocks of samples, then calibration.
// ----------------------------------------------------------------------------
// Takes one ADC sample per cycle. Samples form non-overlapping blocks of
// BLOCK_LEN; the running sum, largest and smallest sample are updated as each
// sample is taken. On the last sample of a block the largest and smallest are
// dropped, the rest is divided by BLOCK_LEN-2 (rounded down), scaled by
// gain/GAIN_BASE (rounded down), offset is added and the value is clamped to
// 0..65535. Only the last sample of a block yields a voltage beat. The
// post-block path is a block register and the five-stage elastic pipeline
// of tbac_calib, so in_ready drops only when the last sample of a block
// arrives while that path is full and the output is stalled. The user writes
// gain and offset only while no block result is in flight; it is not checked.
module trimmed_block_average_calibrate_core #(
	parameter int BLOCK_LEN = 10,
	parameter int GAIN_BASE = 10000,
	parameter int ADC_BITS  = 12
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               cfg_we,
	input  logic [tbac_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  logic [tbac_pkg::CFG_W-1:0]         cfg_data,
	input  logic                               in_valid,
	output logic                               in_ready,
	input  logic [tbac_pkg::SAMPLE_W-1:0]      sample,
	output logic                               out_valid,
	input  logic                               out_ready,
	output logic [tbac_pkg::VOLT_W-1:0]        voltage
);
	import tbac_pkg::*;

	localparam int ADC_W = (ADC_BITS < SAMPLE_W) ? ADC_BITS : SAMPLE_W;
	localparam int CNT_W = $clog2(BLOCK_LEN);
	localparam logic [CNT_W-1:0]    CNT_LAST = CNT_W'(BLOCK_LEN - 1);
	localparam logic [SAMPLE_W-1:0] ADC_MASK = SAMPLE_W'((1 << ADC_W) - 1);

	cfg_t                 cfg_q;
	logic [SUM_W-1:0]     sum_q;
	logic [SAMPLE_W-1:0]  max_q;
	logic [SAMPLE_W-1:0]  min_q;
	logic [CNT_W-1:0]     count_q;

	logic                 valid_s1;
	logic [SUM_W-1:0]     sum_s1;
	logic [SAMPLE_W-1:0]  max_s1;
	logic [SAMPLE_W-1:0]  min_s1;

	logic [SAMPLE_W-1:0]  smp;
	logic                 first;
	logic                 last;
	logic                 accept;
	logic                 s1_ready;
	logic [SUM_W-1:0]     sum_n;
	logic [SAMPLE_W-1:0]  max_n;
	logic [SAMPLE_W-1:0]  min_n;

	assign smp   = sample & ADC_MASK;
	assign first = (count_q == '0);
	assign last  = (count_q == CNT_LAST);

	// only the closing sample of a block needs room downstream
	assign in_ready = !last || !valid_s1 || s1_ready;
	assign accept   = in_valid && in_ready;

	assign sum_n = (first ? '0 : sum_q) + SUM_W'(smp);
	assign max_n = (first || smp > max_q) ? smp : max_q;
	assign min_n = (first || smp < min_q) ? smp : min_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.gain   <= GAIN_RST;
			cfg_q.offset <= OFFSET_RST;
		end else if (cfg_we) begin
			case (cfg_idx_t'(cfg_index))
				CFG_GAIN:   cfg_q.gain   <= cfg_data;
				CFG_OFFSET: cfg_q.offset <= cfg_data;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sum_q    <= '0;
			max_q    <= '0;
			min_q    <= '0;
			count_q  <= '0;
			valid_s1 <= 1'b0;
		end else begin
			if (accept) begin
				max_q <= max_n;
				min_q <= min_n;
				if (last) begin
					sum_q   <= '0;
					count_q <= '0;
				end else begin
					sum_q   <= sum_n;
					count_q <= count_q + CNT_W'(1);
				end
			end
			if (accept && last) begin
				valid_s1 <= 1'b1;
			end else if (s1_ready) begin
				valid_s1 <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept && last) begin
			sum_s1 <= sum_n;
			max_s1 <= max_n;
			min_s1 <= min_n;
		end
	end

	tbac_calib #(
		.BLOCK_LEN (BLOCK_LEN),
		.GAIN_BASE (GAIN_BASE)
	) u_calib (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg_q),
		.in_valid  (valid_s1),
		.in_ready  (s1_ready),
		.blk_sum   (sum_s1),
		.blk_max   (max_s1),
		.blk_min   (min_s1),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.voltage   (voltage)
	);

endmodule

@@ design/tbac_calib.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tbac_calib
// Elastic pipeline that trims a finished block, divides by the trimmed length,
// applies gain over the gain base and the signed offset, and saturates.
// ----------------------------------------------------------------------------
module tbac_calib #(
	parameter int BLOCK_LEN = 10,
	parameter int GAIN_BASE = 10000
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  tbac_pkg::cfg_t                   cfg,
	input  logic                             in_valid,
	output logic                             in_ready,
	input  logic [tbac_pkg::SUM_W-1:0]       blk_sum,
	input  logic [tbac_pkg::SAMPLE_W-1:0]    blk_max,
	input  logic [tbac_pkg::SAMPLE_W-1:0]    blk_min,
	output logic                             out_valid,
	input  logic                             out_ready,
	output logic [tbac_pkg::VOLT_W-1:0]      voltage
);
	import tbac_pkg::*;

	localparam int NST = 5;

	// floor division by a constant via a rounded-up reciprocal, exact over the input range
	localparam int DIV  = BLOCK_LEN - 2;
	localparam int SH1  = SUM_W + $clog2(DIV);
	localparam int M1_W = SH1 + 1;
	localparam logic [M1_W-1:0] M1 =
		M1_W'(((64'd1 << SH1) + 64'(DIV) - 64'd1) / 64'(DIV));
	localparam int P1_W = SUM_W + M1_W;

	localparam int GP_W = SAMPLE_W + GAIN_W;
	localparam int SH2  = GP_W + $clog2(GAIN_BASE);
	localparam int M2_W = GP_W + 2;
	localparam logic [M2_W-1:0] M2 =
		M2_W'(((64'd1 << SH2) + 64'(GAIN_BASE) - 64'd1) / 64'(GAIN_BASE));
	localparam int P2_W = GP_W + M2_W;
	localparam int B_W  = GP_W + 2;

	logic [NST-1:0]       vld_q;
	logic [NST-1:0]       stage_en;
	logic [SUM_W-1:0]     trim_s1;
	logic [P1_W-1:0]      prod_s2;
	logic [GP_W-1:0]      gprod_s3;
	logic [P2_W-1:0]      qprod_s4;
	logic [VOLT_W-1:0]    voltage_s5;

	logic [SAMPLE_W-1:0]  mean;
	logic [GP_W-1:0]      scaled;
	logic signed [B_W-1:0] biased;
	logic [VOLT_W-1:0]    sat;

	// a stage loads when empty or when the one after it moves on
	always_comb begin
		stage_en[NST-1] = !vld_q[NST-1] || out_ready;
		for (int i = NST - 2; i >= 0; i--) begin
			stage_en[i] = !vld_q[i] || stage_en[i+1];
		end
	end

	assign in_ready  = stage_en[0];
	assign out_valid = vld_q[NST-1];
	assign voltage   = voltage_s5;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else begin
			if (stage_en[0]) begin
				vld_q[0] <= in_valid;
			end
			for (int i = 1; i < NST; i++) begin
				if (stage_en[i]) begin
					vld_q[i] <= vld_q[i-1];
				end
			end
		end
	end

	assign mean   = prod_s2[SH1 +: SAMPLE_W];
	assign scaled = GP_W'(qprod_s4 >> SH2);
	assign biased = signed'({2'b00, scaled})
		+ signed'({{(B_W - CFG_W){cfg.offset[CFG_W-1]}}, cfg.offset});

	always_comb begin
		if (biased[B_W-1]) begin
			sat = '0;
		end else if (|biased[B_W-2:VOLT_W]) begin
			sat = '1;
		end else begin
			sat = biased[VOLT_W-1:0];
		end
	end

	always_ff @(posedge clk) begin
		if (stage_en[0]) begin
			trim_s1 <= blk_sum - SUM_W'(blk_max) - SUM_W'(blk_min);
		end
		if (stage_en[1]) begin
			prod_s2 <= P1_W'(trim_s1) * P1_W'(M1);
		end
		if (stage_en[2]) begin
			gprod_s3 <= GP_W'(mean) * GP_W'(cfg.gain);
		end
		if (stage_en[3]) begin
			qprod_s4 <= P2_W'(gprod_s3) * P2_W'(M2);
		end
		if (stage_en[4]) begin
			voltage_s5 <= sat;
		end
	end

endmodule
